>>> src/ats_pkg.sv
// ----------------------------------------------------------------------------
// ats_pkg: shared types and constants of the affine transform stack
// Operation and status codes, the six-word transform record, stream widths
// and the saturation helpers used by the arithmetic datapath.
// ----------------------------------------------------------------------------
package ats_pkg;

    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_FRAC_BITS   = 16;

    localparam int WORD_W     = 32;
    localparam int TRIG_W     = 18;
    localparam int PROD_W     = 64;
    localparam int SUM_W      = 66;
    localparam int COUNT_W    = 5;
    localparam int IN_DATA_W  = 104;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 200;
    localparam int OUT_USER_W = 2;

    typedef enum logic [2:0] {
        OP_PUSH      = 3'd0,
        OP_POP       = 3'd1,
        OP_TRANSLATE = 3'd2,
        OP_SCALE     = 3'd3,
        OP_ROTATE    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
        logic signed [WORD_W-1:0] c;
        logic signed [WORD_W-1:0] d;
        logic signed [WORD_W-1:0] tx;
        logic signed [WORD_W-1:0] ty;
    } xform_t;

    typedef struct packed {
        logic [2:0]               operation;
        logic signed [WORD_W-1:0] arg_x;
        logic signed [WORD_W-1:0] arg_y;
        logic signed [TRIG_W-1:0] rot_cos;
        logic signed [TRIG_W-1:0] rot_sin;
    } request_t;

    function automatic logic signed [SUM_W-1:0] widen_prod(
        input logic signed [PROD_W-1:0] v
    );
        return {{(SUM_W-PROD_W){v[PROD_W-1]}}, v};
    endfunction

    function automatic logic signed [SUM_W-1:0] widen_word(
        input logic signed [WORD_W-1:0] v
    );
        return {{(SUM_W-WORD_W){v[WORD_W-1]}}, v};
    endfunction

    // Clamp a wide signed sum to the signed 32-bit range.
    function automatic logic signed [WORD_W-1:0] sat_word(
        input logic signed [SUM_W-1:0] v
    );
        logic all_zero;
        logic all_one;
        all_zero = ~|v[SUM_W-1:WORD_W-1];
        all_one  = &v[SUM_W-1:WORD_W-1];
        if (all_zero || all_one) begin
            return v[WORD_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(WORD_W-1){1'b1}}};
        end
    endfunction

endpackage

>>> src/affine_transform_stack.sv
// ----------------------------------------------------------------------------
// affine_transform_stack: bounded stack of 2D affine transforms in Q format
// Push, pop, translate, scale and rotate requests act on the top transform;
// every request returns the top transform, the entry count and a status.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle unless a held result stalls it
// and returns exactly one result per request, which passes from the request
// register through the datapath into the result register. The top transform
// lives in registers and all multiplies of a request are combinational on it,
// so back-to-back modifiers see each other's results without any wait. The
// entries below the top sit in a memory whose registered read port always
// holds the entry directly under the top, so a pop takes its new top from it.
// The memory has no reset and needs no clearing pass; an entry is only used
// after being written. A full stack ignores a push and reports overflow, an
// empty stack ignores pop and modifiers and reports empty, and unknown
// operation codes leave everything unchanged with status done.
module affine_transform_stack #(
    parameter int STACK_DEPTH = ats_pkg::DEF_STACK_DEPTH,
    parameter int FRAC_BITS   = ats_pkg::DEF_FRAC_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // arg_x[31:0], arg_y[63:32], rot_cos[81:64], rot_sin[99:82], zero pad
    input  logic [ats_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // operation[2:0]
    input  logic [ats_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // top_a[31:0], top_b[63:32], top_c[95:64], top_d[127:96],
    // top_tx[159:128], top_ty[191:160], stack_count[196:192], zero pad
    output logic [ats_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [ats_pkg::OUT_USER_W-1:0] m_axis_tuser
);
    import ats_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [WORD_W-1:0] Q_ONE = WORD_W'(1) << FRAC_BITS;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    request_t             in_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic [OUT_USER_W-1:0] out_user_reg;
    logic [OUT_USER_W-1:0] out_user_next;
    xform_t               top_reg;
    xform_t               top_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    xform_t               below_reg;
    xform_t               below_next;
    xform_t               stack_mem [STACK_DEPTH];

    logic                 s_fire;
    logic                 advance;
    logic                 proc;
    logic                 mem_we;
    logic [CNT_W-1:0]     wr_diff;
    logic [CNT_W-1:0]     rd_diff;
    logic [IDX_W-1:0]     wr_addr;
    logic [IDX_W-1:0]     rd_addr;
    status_t              status_next;
    xform_t               shown;
    logic                 is_empty;
    logic                 is_full;

    logic signed [WORD_W-1:0] f0;
    logic signed [WORD_W-1:0] f1;
    logic signed [WORD_W-1:0] mul_l [8];
    logic signed [WORD_W-1:0] mul_r [8];
    logic signed [PROD_W-1:0] prod [8];
    logic signed [SUM_W-1:0]  qp [8];

    assign s_fire  = s_axis_tvalid && s_axis_tready;
    assign advance = !out_valid_reg || m_axis_tready;
    assign proc    = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    assign in_valid_next  = s_fire || (in_valid_reg && !advance);
    assign out_valid_next = proc || (out_valid_reg && !m_axis_tready);

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_FULL);

    // Multiplier operands are shared between translate, scale and rotate.
    always_comb begin
        if (in_reg.operation == OP_ROTATE) begin
            f0 = {{(WORD_W-TRIG_W){in_reg.rot_cos[TRIG_W-1]}}, in_reg.rot_cos};
            f1 = {{(WORD_W-TRIG_W){in_reg.rot_sin[TRIG_W-1]}}, in_reg.rot_sin};
        end else begin
            f0 = in_reg.arg_x;
            f1 = in_reg.arg_y;
        end
        mul_l[0] = top_reg.a;  mul_r[0] = f0;
        mul_l[1] = top_reg.c;  mul_r[1] = f1;
        mul_l[2] = top_reg.b;  mul_r[2] = f0;
        mul_l[3] = top_reg.d;  mul_r[3] = f1;
        mul_l[4] = top_reg.c;  mul_r[4] = f0;
        mul_l[5] = top_reg.a;  mul_r[5] = f1;
        mul_l[6] = top_reg.d;  mul_r[6] = f0;
        mul_l[7] = top_reg.b;  mul_r[7] = f1;
        for (int i = 0; i < 8; i++) begin
            prod[i] = $signed({{(PROD_W-WORD_W){mul_l[i][WORD_W-1]}}, mul_l[i]})
                    * $signed({{(PROD_W-WORD_W){mul_r[i][WORD_W-1]}}, mul_r[i]});
            qp[i] = widen_prod(prod[i] >>> FRAC_BITS);
        end
    end

    always_comb begin
        top_next    = top_reg;
        count_next  = count_reg;
        status_next = ST_DONE;
        mem_we      = 1'b0;
        if (proc) begin
            case (in_reg.operation)
                OP_PUSH: begin
                    if (is_full) begin
                        status_next = ST_OVERFLOW;
                    end else if (is_empty) begin
                        top_next   = '{a: Q_ONE, b: '0, c: '0, d: Q_ONE, tx: '0, ty: '0};
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_POP: begin
                    if (is_empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        top_next   = below_reg;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                OP_TRANSLATE: begin
                    if (is_empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        top_next.tx = sat_word(widen_word(top_reg.tx) + qp[0] + qp[1]);
                        top_next.ty = sat_word(widen_word(top_reg.ty) + qp[2] + qp[3]);
                    end
                end
                OP_SCALE: begin
                    if (is_empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        top_next.a = sat_word(qp[0]);
                        top_next.b = sat_word(qp[2]);
                        top_next.c = sat_word(qp[1]);
                        top_next.d = sat_word(qp[3]);
                    end
                end
                OP_ROTATE: begin
                    if (is_empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        top_next.a = sat_word(qp[0] + qp[1]);
                        top_next.b = sat_word(qp[2] + qp[3]);
                        top_next.c = sat_word(qp[4] - qp[5]);
                        top_next.d = sat_word(qp[6] - qp[7]);
                    end
                end
                default: begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    // On a push onto a non-empty stack the current top is written below itself;
    // the read port follows the entry under the next top, with a bypass for that write.
    assign wr_diff = count_reg - CNT_W'(1);
    assign rd_diff = count_next - CNT_W'(2);
    assign wr_addr = wr_diff[IDX_W-1:0];
    assign rd_addr = rd_diff[IDX_W-1:0];

    assign shown = (count_next == '0) ? '0 : top_next;

    always_comb begin
        if (proc) begin
            out_data_next = {{(OUT_DATA_W-6*WORD_W-COUNT_W){1'b0}},
                             COUNT_W'(count_next),
                             shown.ty, shown.tx, shown.d, shown.c, shown.b, shown.a};
            out_user_next = status_next;
        end else begin
            out_data_next = out_data_reg;
            out_user_next = out_user_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[wr_addr] <= top_reg;
        end
        if (mem_we && (wr_addr == rd_addr)) begin
            below_reg <= top_reg;
        end else begin
            below_reg <= stack_mem[rd_addr];
        end
    end

    assign below_next = below_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg <= '{operation: s_axis_tuser[2:0],
                        arg_x:     s_axis_tdata[31:0],
                        arg_y:     s_axis_tdata[63:32],
                        rot_cos:   s_axis_tdata[81:64],
                        rot_sin:   s_axis_tdata[99:82]};
        end
        top_reg      <= top_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("entry count exceeds the stack depth");

    a_full_push_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && in_reg.operation == OP_PUSH && is_full)
        |=> (count_reg == $past(count_reg) && out_user_reg == ST_OVERFLOW))
        else $error("push on a full stack changed the count or missed overflow");

    a_stalled_request_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_reg)))
        else $error("pending request lost while the result register was full");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        proc |=> (m_axis_tvalid && $past(count_next) == count_reg))
        else $error("processed request did not produce a result");

    a_below_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (!proc && !$past(proc) && count_reg > CNT_W'(1))
        |=> (below_reg == $past(below_next)))
        else $error("entry under the top changed while no request was processed");

endmodule

>>> tb/affine_transform_stack_test.sv
// ----------------------------------------------------------------------------
// affine_transform_stack_test: self-checking testbench of the transform stack
// A directed sequence covers the empty stack, unknown operation codes, the
// saturating corners of every modifier and out-of-range trig values. Random
// phases with push-heavy and pop-heavy stretches then fill and drain the
// stack under varying source idling and sink back-pressure. A local model
// predicts every result, and each returned result is checked field by field.
// ----------------------------------------------------------------------------
module affine_transform_stack_test;

    import ats_pkg::*;

    localparam int DEPTH       = DEF_STACK_DEPTH;
    localparam int FRAC        = DEF_FRAC_BITS;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 64;
    localparam int PHASE_ITEMS = 96;
    localparam int REPORT_MAX  = 10;
    localparam logic signed [WORD_W-1:0] ONE_Q = 1 << FRAC;
    localparam logic [WORD_W-1:0] W_MAX = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] W_MIN = 32'h8000_0000;
    localparam logic [TRIG_W-1:0] T_ONE = 18'h1_0000;
    localparam logic [TRIG_W-1:0] T_NEG = 18'h3_0000;
    localparam logic [2:0] OP_UNKNOWN_LO = 3'(OP_ROTATE + 1);
    localparam logic [2:0] OP_UNKNOWN_HI = 3'b111;

    typedef struct packed {
        xform_t             top;
        logic [COUNT_W-1:0] count;
        status_t            status;
    } top_result_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    affine_transform_stack u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    request_t    request_queue[$];
    top_result_t expected_tops[$];

    xform_t stack_mem[DEPTH];
    int     stack_len;

    int  src_idle_pct  = 0;
    int  snk_stall_pct = 0;
    int  hold_reqs     = 0;
    int  hold_taken    = 0;
    int  hold_left     = 0;
    logic in_taken     = 1'b0;
    int  quiet_cycles  = 0;
    int  mismatches    = 0;
    int  checked       = 0;
    int  requests_sent = 0;
    int  overflow_seen = 0;
    int  empty_seen    = 0;
    int  deepest       = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic longint mul_floor(longint p, longint q);
        return (p * q) >>> FRAC;
    endfunction

    function automatic logic signed [WORD_W-1:0] clamp_word(longint v);
        if (v > longint'(32'sh7fff_ffff)) begin
            return W_MAX;
        end else if (v < -longint'(64'h8000_0000)) begin
            return W_MIN;
        end
        return v[WORD_W-1:0];
    endfunction

    // Applies one request to the local copy of the stack and returns the result.
    function automatic top_result_t apply_request(request_t r);
        top_result_t res;
        xform_t      t;
        longint      a, b, c, d, x, y, cs, sn;
        res.status = ST_DONE;
        case (r.operation)
            OP_PUSH: begin
                if (stack_len >= DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    if (stack_len == 0) begin
                        t   = '0;
                        t.a = ONE_Q;
                        t.d = ONE_Q;
                    end else begin
                        t = stack_mem[stack_len-1];
                    end
                    stack_mem[stack_len] = t;
                    stack_len++;
                end
            end
            OP_POP, OP_TRANSLATE, OP_SCALE, OP_ROTATE: begin
                if (stack_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (r.operation == OP_POP) begin
                    stack_len--;
                end else begin
                    t  = stack_mem[stack_len-1];
                    a  = t.a;
                    b  = t.b;
                    c  = t.c;
                    d  = t.d;
                    x  = r.arg_x;
                    y  = r.arg_y;
                    cs = r.rot_cos;
                    sn = r.rot_sin;
                    case (r.operation)
                        OP_TRANSLATE: begin
                            t.tx = clamp_word(longint'(t.tx) + mul_floor(a, x)
                                              + mul_floor(c, y));
                            t.ty = clamp_word(longint'(t.ty) + mul_floor(b, x)
                                              + mul_floor(d, y));
                        end
                        OP_SCALE: begin
                            t.a = clamp_word(mul_floor(a, x));
                            t.b = clamp_word(mul_floor(b, x));
                            t.c = clamp_word(mul_floor(c, y));
                            t.d = clamp_word(mul_floor(d, y));
                        end
                        default: begin
                            t.a = clamp_word(mul_floor(a, cs) + mul_floor(c, sn));
                            t.b = clamp_word(mul_floor(b, cs) + mul_floor(d, sn));
                            t.c = clamp_word(mul_floor(c, cs) - mul_floor(a, sn));
                            t.d = clamp_word(mul_floor(d, cs) - mul_floor(b, sn));
                        end
                    endcase
                    stack_mem[stack_len-1] = t;
                end
            end
            default: ;
        endcase
        if (stack_len > deepest) begin
            deepest = stack_len;
        end
        res.top   = (stack_len > 0) ? stack_mem[stack_len-1] : '0;
        res.count = COUNT_W'(stack_len);
        return res;
    endfunction

    function automatic string show(top_result_t r);
        return $sformatf("a=%h b=%h c=%h d=%h tx=%h ty=%h count=%0d status=%s",
            r.top.a, r.top.b, r.top.c, r.top.d, r.top.tx, r.top.ty, r.count, r.status.name());
    endfunction

    function automatic request_t make_request(logic [2:0] op, logic [WORD_W-1:0] x,
                                              logic [WORD_W-1:0] y, logic [TRIG_W-1:0] cs,
                                              logic [TRIG_W-1:0] sn);
        request_t r;
        r.operation = op;
        r.arg_x     = x;
        r.arg_y     = y;
        r.rot_cos   = cs;
        r.rot_sin   = sn;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: begin
                case ($urandom_range(0, 3))
                    0: return W_MAX;
                    1: return W_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return 32'($urandom_range(0, 262144)) - 32'd131072;
        endcase
    endfunction

    function automatic logic [TRIG_W-1:0] rand_trig();
        case ($urandom_range(0, 9))
            0: return TRIG_W'($urandom());
            1: begin
                case ($urandom_range(0, 2))
                    0: return T_ONE;
                    1: return T_NEG;
                    default: return '0;
                endcase
            end
            default: return TRIG_W'($urandom_range(0, 131072)) - TRIG_W'(65536);
        endcase
    endfunction

    function automatic request_t rand_request(int push_pct);
        int       pick;
        logic [2:0] op;
        pick = $urandom_range(0, 99);
        if (pick < push_pct) begin
            op = OP_PUSH;
        end else if (pick < push_pct + (100 - push_pct) / 4) begin
            op = OP_POP;
        end else if (pick >= 97) begin
            op = 3'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
        end else begin
            op = 3'($urandom_range(OP_TRANSLATE, OP_ROTATE));
        end
        return make_request(op, rand_word(), rand_word(), rand_trig(), rand_trig());
    endfunction

    function automatic void queue_request(request_t r);
        request_queue.insert(request_queue.size(), r);
    endfunction

    // Request driver.
    always @(negedge aclk) begin
        request_t r;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (request_queue.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                r = request_queue.pop_front();
                s_axis_tdata  <= {4'b0, r.rot_sin, r.rot_cos, r.arg_y, r.arg_x};
                s_axis_tuser  <= r.operation;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result sink with random stalls and an occasional long hold-off.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_taken != hold_reqs) begin
            hold_taken    <= hold_reqs;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // Monitor: checks results, predicts accepted requests, watches for a hang.
    always @(posedge aclk) begin
        top_result_t got;
        top_result_t want;
        request_t    r;
        logic        in_fire;
        logic        out_fire;
        in_fire  = aresetn && s_axis_tvalid && s_axis_tready;
        out_fire = aresetn && m_axis_tvalid && m_axis_tready;
        in_taken <= in_fire;
        if (out_fire) begin
            got.top.a  = m_axis_tdata[31:0];
            got.top.b  = m_axis_tdata[63:32];
            got.top.c  = m_axis_tdata[95:64];
            got.top.d  = m_axis_tdata[127:96];
            got.top.tx = m_axis_tdata[159:128];
            got.top.ty = m_axis_tdata[191:160];
            got.count  = m_axis_tdata[196:192];
            got.status = status_t'(m_axis_tuser);
            if (expected_tops.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("Unexpected result: %s", show(got));
                end
            end else begin
                want = expected_tops.pop_front();
                checked++;
                if (got.top.a != want.top.a || got.top.b != want.top.b
                        || got.top.c != want.top.c || got.top.d != want.top.d
                        || got.top.tx != want.top.tx || got.top.ty != want.top.ty
                        || got.count != want.count || got.status != want.status) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("Mismatch on result %0d at %0t:", checked, $time);
                        $display("  expected %s", show(want));
                        $display("  actual   %s", show(got));
                    end
                end
            end
        end
        if (in_fire) begin
            r.operation = s_axis_tuser;
            r.arg_x     = s_axis_tdata[31:0];
            r.arg_y     = s_axis_tdata[63:32];
            r.rot_cos   = s_axis_tdata[81:64];
            r.rot_sin   = s_axis_tdata[99:82];
            want = apply_request(r);
            if (want.status == ST_OVERFLOW) begin
                overflow_seen++;
            end
            if (want.status == ST_EMPTY) begin
                empty_seen++;
            end
            requests_sent++;
            expected_tops.insert(expected_tops.size(), want);
        end
        if (in_fire || out_fire) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
            $display("affine_transform_stack_test: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic drain();
        while (request_queue.size() != 0 || s_axis_tvalid || expected_tops.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, bit with_hold);
        int push_bias[6] = '{75, 20, 45, 85, 10, 50};
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            queue_request(rand_request(push_bias[(i / 20) % 6]));
        end
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        if (with_hold) begin
            hold_reqs++;
        end
        drain();
    endtask

    initial begin
        stack_len = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty stack, unknown codes, saturating corners and odd trig values.
        queue_request(make_request(OP_POP, '0, '0, '0, '0));
        queue_request(make_request(OP_TRANSLATE, ONE_Q, ONE_Q, '0, '0));
        queue_request(make_request(OP_SCALE, ONE_Q, ONE_Q, '0, '0));
        queue_request(make_request(OP_ROTATE, '0, '0, T_ONE, T_ONE));
        queue_request(make_request(OP_UNKNOWN_LO, W_MAX, W_MIN, T_ONE, T_NEG));
        queue_request(make_request(OP_UNKNOWN_HI, '1, '1, '1, '1));
        queue_request(make_request(OP_PUSH, '1, '1, '1, '1));
        queue_request(make_request(OP_TRANSLATE, W_MAX, W_MAX, '0, '0));
        queue_request(make_request(OP_TRANSLATE, W_MIN, W_MIN, '0, '0));
        queue_request(make_request(OP_SCALE, W_MAX, W_MIN, '0, '0));
        queue_request(make_request(OP_PUSH, '0, '0, '0, '0));
        queue_request(make_request(OP_ROTATE, '0, '0, T_ONE, T_NEG));
        queue_request(make_request(OP_ROTATE, '0, '0, 18'h2_0000, 18'h1_ffff));
        queue_request(make_request(OP_SCALE, '1, ONE_Q, '0, '0));
        queue_request(make_request(OP_UNKNOWN_LO + 3'd1, '0, '0, '0, '0));
        queue_request(make_request(OP_POP, '0, '0, '0, '0));
        queue_request(make_request(OP_POP, '0, '0, '0, '0));
        queue_request(make_request(OP_POP, '0, '0, '0, '0));
        queue_request(make_request(OP_PUSH, '0, '0, '0, '0));
        queue_request(make_request(OP_ROTATE, '0, '0, '0, T_ONE));
        queue_request(make_request(OP_TRANSLATE, ONE_Q, -ONE_Q, '0, '0));
        queue_request(make_request(OP_SCALE, '0, '0, '0, '0));
        queue_request(make_request(OP_TRANSLATE, W_MAX, W_MIN, '0, '0));
        queue_request(make_request(OP_POP, '0, '0, '0, '0));
        drain();

        run_phase(0, 0, 1'b1);
        run_phase(73, 0, 1'b0);
        run_phase(0, 73, 1'b0);
        run_phase(13, 13, 1'b0);
        run_phase(0, 0, 1'b0);

        repeat (10) @(posedge aclk);
        $display("Covered %0d requests and %0d checked results: %0d overflows, %0d empty-stack",
                 requests_sent, checked, overflow_seen, empty_seen);
        $display("ignores, deepest stack %0d of %0d, with idling, stalls and a long hold-off.",
                 deepest, DEPTH);
        if (mismatches == 0 && expected_tops.size() == 0) begin
            $display("affine_transform_stack_test: PASS");
        end else begin
            $display("Mismatches: %0d, results still expected: %0d",
                     mismatches, expected_tops.size());
            $display("affine_transform_stack_test: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
src/ats_pkg.sv
src/affine_transform_stack.sv
tb/affine_transform_stack_test.sv
